FILE: sv/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg: shared constants for the sorted set table
// Capacity, derived widths and operation codes.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned Capacity  = 16;
  localparam int unsigned ValW      = 32;
  localparam int unsigned OpW       = 2;
  localparam int unsigned CountOutW = 5;
  localparam int unsigned CntW      = $clog2(Capacity + 1);
  localparam int unsigned IdxW      = $clog2(Capacity);

  localparam logic [OpW-1:0] OpInsert = 2'd0;
  localparam logic [OpW-1:0] OpRemove = 2'd1;
  localparam logic [OpW-1:0] OpQuery  = 2'd2;

endpackage

FILE: sv/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/sorted_set_table.sv
// ----------------------------------------------------------------------------
// sorted_set_table: ordered set of distinct signed 32-bit values
// Insert, remove and membership query over a RAM held in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   A word (operation_i, value_i) is taken on a rising edge with start_i high
//   and busy_o low. busy_o stays high until the result is out. The result
//   (present_o, count_o, status_o) is valid for exactly one cycle, marked by
//   done_o; the receiver cannot stall it. busy_o is low during that cycle, so
//   the next word may be taken on the edge that ends it.
//   Steps, with n entries held and p the sorted position of the value:
//     search: SRd and SCmp read entries in ascending order up to p
//     insert of an absent value: entries p..n-1 move up, then SPut writes
//     remove of a present value: entries p+1..n-1 move down one place
//     before any shift, SAct decides the action; the result is registered.
//   Each shift step reads one entry (SShRd), then writes it (SShWr).
//   An insert into a full set is refused with status_o high.
//   Operation code 3 behaves as a query.
//   Reset empties the set at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_set_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [sst_pkg::OpW-1:0]             operation_i,
  input  logic signed [sst_pkg::ValW-1:0]     value_i,
  output logic                                done_o,
  output logic                                present_o,
  output logic [sst_pkg::CountOutW-1:0]       count_o,
  output logic                                status_o
);

  localparam int unsigned CntW = sst_pkg::CntW;
  localparam int unsigned IdxW = sst_pkg::IdxW;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SRd   = 3'd1;
  localparam logic [2:0] SCmp  = 3'd2;
  localparam logic [2:0] SAct  = 3'd3;
  localparam logic [2:0] SShRd = 3'd4;
  localparam logic [2:0] SShWr = 3'd5;
  localparam logic [2:0] SPut  = 3'd6;

  logic [2:0]                     state_q, state_d;
  logic [sst_pkg::OpW-1:0]        op_q, op_d;
  logic signed [sst_pkg::ValW-1:0] key_q, key_d;
  logic                           found_q, found_d;
  logic [CntW-1:0]                pos_q, pos_d;
  logic [CntW-1:0]                j_q, j_d;
  logic [CntW-1:0]                count_q, count_d;
  logic                           done_q, done_d;
  logic                           present_q, present_d;
  logic                           status_q, status_d;

  logic                           ram_we;
  logic [IdxW-1:0]                ram_waddr, ram_raddr;
  logic [sst_pkg::ValW-1:0]       ram_wdata, ram_rdata;
  logic signed [sst_pkg::ValW-1:0] rd_val;

  logic [CntW-1:0] j_m1, j_p1, pos_p1, count_m1;
  logic            is_ins;

  assign rd_val   = $signed(ram_rdata);
  assign j_m1     = j_q - CntW'(1);
  assign j_p1     = j_q + CntW'(1);
  assign pos_p1   = pos_q + CntW'(1);
  assign count_m1 = count_q - CntW'(1);
  assign is_ins   = (op_q == sst_pkg::OpInsert);

  sst_ram #(
    .Width(sst_pkg::ValW),
    .Depth(sst_pkg::Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    found_d   = found_q;
    pos_d     = pos_q;
    j_d       = j_q;
    count_d   = count_q;
    done_d    = 1'b0;
    present_d = present_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = j_q[IdxW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = pos_q[IdxW-1:0];

    case (state_q)
      SIdle: begin
        if (start_i) begin
          op_d    = operation_i;
          key_d   = value_i;
          found_d = 1'b0;
          pos_d   = '0;
          state_d = (count_q == '0) ? SAct : SRd;
        end
      end
      SRd: begin
        ram_raddr = pos_q[IdxW-1:0];
        state_d   = SCmp;
      end
      SCmp: begin
        if (rd_val < key_q) begin
          pos_d = pos_p1;
          state_d = (pos_p1 < count_q) ? SRd : SAct;
        end else begin
          found_d = (rd_val == key_q);
          state_d = SAct;
        end
      end
      SAct: begin
        status_d = 1'b0;
        if (is_ins && !found_q) begin
          if (count_q == CntW'(sst_pkg::Capacity)) begin
            status_d  = 1'b1;
            present_d = 1'b0;
            done_d    = 1'b1;
            state_d   = SIdle;
          end else begin
            j_d     = count_q;
            state_d = (count_q == pos_q) ? SPut : SShRd;
          end
        end else if ((op_q == sst_pkg::OpRemove) && found_q) begin
          j_d = pos_q;
          if (pos_p1 < count_q) begin
            state_d = SShRd;
          end else begin
            count_d   = count_m1;
            present_d = 1'b1;
            done_d    = 1'b1;
            state_d   = SIdle;
          end
        end else begin
          present_d = found_q;
          done_d    = 1'b1;
          state_d   = SIdle;
        end
      end
      SShRd: begin
        ram_raddr = is_ins ? j_m1[IdxW-1:0] : j_p1[IdxW-1:0];
        state_d   = SShWr;
      end
      SShWr: begin
        ram_we    = 1'b1;
        ram_waddr = j_q[IdxW-1:0];
        ram_wdata = ram_rdata;
        if (is_ins) begin
          j_d     = j_m1;
          state_d = (j_m1 == pos_q) ? SPut : SShRd;
        end else begin
          j_d = j_p1;
          if (j_p1 < count_m1) begin
            state_d = SShRd;
          end else begin
            count_d   = count_m1;
            present_d = 1'b1;
            done_d    = 1'b1;
            state_d   = SIdle;
          end
        end
      end
      SPut: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[IdxW-1:0];
        ram_wdata = key_q;
        count_d   = count_q + CntW'(1);
        present_d = 1'b0;
        done_d    = 1'b1;
        state_d   = SIdle;
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      count_q   <= '0;
      done_q    <= 1'b0;
      present_q <= 1'b0;
      status_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      done_q    <= done_d;
      present_q <= present_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    key_q   <= key_d;
    found_q <= found_d;
    pos_q   <= pos_d;
    j_q     <= j_d;
  end

  assign busy_o    = (state_q != SIdle);
  assign done_o    = done_q;
  assign present_o = present_q;
  assign status_o  = status_q;
  assign count_o   = sst_pkg::CountOutW'(count_q);

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(sst_pkg::Capacity))
    else $error("count above capacity");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not raise busy");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (!present_o && count_q == CntW'(sst_pkg::Capacity)))
    else $error("reject without full set");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> done_o)
    else $error("count changed outside a result");
`endif

endmodule
